// ===== design/gdq_pkg.sv =====
// Shared types, constants and the scale decoder for the block-scaled
// 3-bit dequantising dot product. No dependencies.
`default_nettype none

package gdq_pkg;

  localparam int LANES      = 8;
  localparam int LANE_IDX_W = $clog2(LANES);
  localparam int CODE_W     = 3;
  localparam int CODE_BASE  = 8;
  localparam int ACT_W      = 16;
  localparam int TAG_W      = 16;
  localparam int GROUP_W    = 32;
  localparam int SCALE_W    = 8;
  localparam int EXP_W      = 5;
  localparam int MAG_W      = 3;
  // (4 - code) * magnitude * activation fits in 24 signed bits
  localparam int PROD_W     = 24;
  // product shifted by up to 30 places, plus sign
  localparam int TERM_W     = 53;
  localparam int ACC_W      = 64;

  localparam logic [EXP_W-1:0] EXP_INF_NAN = 5'd31;
  localparam logic [EXP_W-1:0] EXP_SUBNORM = 5'd0;
  localparam logic [EXP_W-1:0] SUBNORM_SHIFT = 5'd1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Decoded fp8 e5m2 group scale
  typedef struct packed {
    logic             neg;
    logic             bad;
    logic [MAG_W-1:0] mag;
    logic [EXP_W-1:0] shamt;
  } scale_t;

  // Per-transaction control handed to the merging stage
  typedef struct packed {
    logic last;
    logic bad;
  } grp_ctl_t;

  typedef enum logic {
    MS_IDLE,
    MS_MERGE
  } merge_state_t;

  // Split the scale into sign, integer mantissa and shift amount
  function automatic scale_t decode_scale(input logic [SCALE_W-1:0] sc);
    scale_t           d;
    logic [EXP_W-1:0] ex;
    ex      = sc[6:2];
    d.neg   = sc[7];
    d.bad   = (ex == EXP_INF_NAN);
    d.mag   = (ex == EXP_SUBNORM) ? {1'b0, sc[1:0]} : {1'b1, sc[1:0]};
    d.shamt = (ex == EXP_SUBNORM) ? SUBNORM_SHIFT : ex;
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/gdq_lane.sv =====
// One dequantising multiply lane: code and scale times activation,
// registered as an exact term in units of 2^-29. Depends on gdq_pkg.
`default_nettype none

module gdq_lane (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire gdq_pkg::scale_t                    scale,
  input  wire logic [gdq_pkg::CODE_W-1:0]         code,
  input  wire logic signed [gdq_pkg::ACT_W-1:0]   act,
  output logic signed [gdq_pkg::TERM_W-1:0]       term
);
  import gdq_pkg::*;

  logic signed [3:0]        weight;
  logic signed [7:0]        wmag;
  logic signed [PROD_W-1:0] prod;
  logic signed [TERM_W-1:0] shifted;
  logic signed [TERM_W-1:0] term_nxt;
  logic signed [TERM_W-1:0] term_r;

  // Form the weight, multiply, scale by the exponent, apply the sign
  always_comb begin
    weight   = 4'sd4 - $signed({1'b0, code});
    wmag     = weight * $signed({1'b0, scale.mag});
    prod     = wmag * act;
    shifted  = TERM_W'(prod) <<< scale.shamt;
    term_nxt = shifted;
    if (scale.bad) begin
      term_nxt = '0;
    end else if (scale.neg) begin
      term_nxt = -shifted;
    end
  end

  // Hold the term until the next transaction
  always_ff @(posedge clk) begin
    if (load) begin
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule

`default_nettype wire

// ===== design/gdq_merge.sv =====
// Merging stage: walks the lane terms in lane order through one saturating
// 64-bit adder, keeps the row flags and holds the result. Depends on gdq_pkg.
`default_nettype none

module gdq_merge (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          start,
  input  wire gdq_pkg::grp_ctl_t                             ctl,
  input  wire logic [gdq_pkg::TAG_W-1:0]                     tag,
  input  wire logic [gdq_pkg::LANES-1:0][gdq_pkg::TERM_W-1:0] terms,
  input  wire logic                                          out_stall,
  output logic                                               busy,
  output logic                                               out_valid,
  output logic signed [gdq_pkg::ACC_W-1:0]                   out_dot_sum,
  output logic [gdq_pkg::TAG_W-1:0]                          out_row_tag_out,
  output logic                                               out_saturated,
  output logic                                               out_bad_scale
);
  import gdq_pkg::*;

  merge_state_t           state_r, state_nxt;
  logic [LANE_IDX_W-1:0]  idx_r, idx_nxt;
  logic                   last_r, last_nxt;
  logic [TAG_W-1:0]       tag_r, tag_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                   clip_r, clip_nxt;
  logic                   bad_r, bad_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic signed [ACC_W-1:0] osum_r, osum_nxt;
  logic [TAG_W-1:0]       otag_r, otag_nxt;
  logic                   osat_r, osat_nxt;
  logic                   obad_r, obad_nxt;

  logic signed [ACC_W-1:0] term_ext;
  logic signed [ACC_W:0]   sum_wide;
  logic                    ovf;
  logic signed [ACC_W-1:0] sat_sum;
  logic                    final_step;
  logic                    emit_ok;

  // Saturating add of the selected lane term
  always_comb begin
    term_ext = ACC_W'($signed(terms[idx_r]));
    sum_wide = {acc_r[ACC_W-1], acc_r} + {term_ext[ACC_W-1], term_ext};
    ovf      = (sum_wide[ACC_W] != sum_wide[ACC_W-1]);
    sat_sum  = ovf ? (sum_wide[ACC_W] ? ACC_MIN : ACC_MAX) : sum_wide[ACC_W-1:0];
  end

  // Sequence the lanes, then emit on the last group of a row
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;
    tag_nxt    = tag_r;
    acc_nxt    = acc_r;
    clip_nxt   = clip_r;
    bad_nxt    = bad_r;
    ovalid_nxt = ovalid_r;
    osum_nxt   = osum_r;
    otag_nxt   = otag_r;
    osat_nxt   = osat_r;
    obad_nxt   = obad_r;

    final_step = (state_r == MS_MERGE) && (idx_r == LANE_IDX_W'(LANES - 1));
    emit_ok    = !last_r || !ovalid_r || !out_stall;

    // drop the result once taken
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      MS_IDLE: begin
        if (start) begin
          state_nxt = MS_MERGE;
          idx_nxt   = '0;
          last_nxt  = ctl.last;
          tag_nxt   = tag;
          bad_nxt   = bad_r | ctl.bad;
        end
      end
      MS_MERGE: begin
        if (!final_step) begin
          acc_nxt  = sat_sum;
          clip_nxt = clip_r | ovf;
          idx_nxt  = idx_r + 1'b1;
        end else if (emit_ok) begin
          state_nxt = MS_IDLE;
          if (last_r) begin
            ovalid_nxt = 1'b1;
            osum_nxt   = sat_sum;
            otag_nxt   = tag_r;
            osat_nxt   = clip_r | ovf;
            obad_nxt   = bad_r;
            acc_nxt    = '0;
            clip_nxt   = 1'b0;
            bad_nxt    = 1'b0;
          end else begin
            acc_nxt  = sat_sum;
            clip_nxt = clip_r | ovf;
          end
        end
      end
      default: begin
        state_nxt = MS_IDLE;
      end
    endcase
  end

  // Control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= MS_IDLE;
      idx_r    <= '0;
      acc_r    <= '0;
      clip_r   <= 1'b0;
      bad_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      acc_r    <= acc_nxt;
      clip_r   <= clip_nxt;
      bad_r    <= bad_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    tag_r  <= tag_nxt;
    osum_r <= osum_nxt;
    otag_r <= otag_nxt;
    osat_r <= osat_nxt;
    obad_r <= obad_nxt;
  end

  assign busy            = (state_r != MS_IDLE);
  assign out_valid       = ovalid_r;
  assign out_dot_sum     = osum_r;
  assign out_row_tag_out = otag_r;
  assign out_saturated   = osat_r;
  assign out_bad_scale   = obad_r;

endmodule

`default_nettype wire

// ===== design/gf4_dequant_dot_product_core.sv =====
// Top level of the block-scaled 3-bit dequantising dot product.
// Depends on gdq_pkg, gdq_lane and gdq_merge.
//
// Each transaction brings one 32-bit weight group (fp8 e5m2 scale plus eight
// 3-bit codes) and eight Q3.12 activations. Eight lanes dequantise and
// multiply in the cycle of acceptance; the merging stage then adds the eight
// exact terms in lane order through a single saturating 64-bit adder, one
// lane a cycle. The input stalls while that serial adder works through the
// lanes, and the next transaction is taken once the merge is done. On a
// group marked last, the row sum (LSB 2^-29), row tag, saturation and bad
// scale flags appear in an output register, and the accumulator and flags
// clear. A waiting result does not block the next group; only the final
// merge step of a following last group waits for the output to be taken.
`default_nettype none

module gf4_dequant_dot_product_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [gdq_pkg::GROUP_W-1:0]           in_weight_group,
  input  wire logic signed [gdq_pkg::ACT_W-1:0]      in_act_0,
  input  wire logic signed [gdq_pkg::ACT_W-1:0]      in_act_1,
  input  wire logic signed [gdq_pkg::ACT_W-1:0]      in_act_2,
  input  wire logic signed [gdq_pkg::ACT_W-1:0]      in_act_3,
  input  wire logic signed [gdq_pkg::ACT_W-1:0]      in_act_4,
  input  wire logic signed [gdq_pkg::ACT_W-1:0]      in_act_5,
  input  wire logic signed [gdq_pkg::ACT_W-1:0]      in_act_6,
  input  wire logic signed [gdq_pkg::ACT_W-1:0]      in_act_7,
  input  wire logic [gdq_pkg::TAG_W-1:0]             in_row_tag,
  input  wire logic                                  in_last_group,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [gdq_pkg::ACC_W-1:0]           out_dot_sum,
  output logic [gdq_pkg::TAG_W-1:0]                  out_row_tag_out,
  output logic                                       out_saturated,
  output logic                                       out_bad_scale
);
  import gdq_pkg::*;

  logic                             busy;
  logic                             accept;
  scale_t                           scale;
  grp_ctl_t                         ctl;
  logic signed [ACT_W-1:0]          acts [LANES];
  logic [LANES-1:0][TERM_W-1:0]     terms;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;

  // Decode the group scale once for all lanes
  assign scale    = decode_scale(in_weight_group[SCALE_W-1:0]);
  assign ctl.last = in_last_group;
  assign ctl.bad  = scale.bad;

  assign acts[0] = in_act_0;
  assign acts[1] = in_act_1;
  assign acts[2] = in_act_2;
  assign acts[3] = in_act_3;
  assign acts[4] = in_act_4;
  assign acts[5] = in_act_5;
  assign acts[6] = in_act_6;
  assign acts[7] = in_act_7;

  // Lanes work side by side on the eight codes
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic signed [TERM_W-1:0] lane_term;

    gdq_lane u_lane (
      .clk   (clk),
      .load  (accept),
      .scale (scale),
      .code  (in_weight_group[CODE_BASE + k*CODE_W +: CODE_W]),
      .act   (acts[k]),
      .term  (lane_term)
    );

    assign terms[k] = lane_term;
  end

  gdq_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (accept),
    .ctl             (ctl),
    .tag             (in_row_tag),
    .terms           (terms),
    .out_stall       (out_stall),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_dot_sum     (out_dot_sum),
    .out_row_tag_out (out_row_tag_out),
    .out_saturated   (out_saturated),
    .out_bad_scale   (out_bad_scale)
  );

endmodule

`default_nettype wire

// ===== design/gdq_checker.sv =====
// Port-level checks for gf4_dequant_dot_product_core and the bind that
// attaches them. Depends on gdq_pkg and the top level.
`default_nettype none

module gdq_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             in_last_group,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic signed [gdq_pkg::ACC_W-1:0] out_dot_sum,
  input wire logic [gdq_pkg::TAG_W-1:0]        out_row_tag_out
);
  import gdq_pkg::*;

  // A transaction occupies the merge for all lanes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##LANES in_stall)
    else $error("input taken again before all lanes were merged");

  // A group that is not last never waits for the output
  a_free_after_merge: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_group |-> ##(LANES + 1) !in_stall)
    else $error("merge did not release after a non-final group");

  // A result only appears at the end of a merge
  a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a merge in progress");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dot_sum)
      && $stable(out_row_tag_out))
    else $error("stalled result changed");

endmodule

bind gf4_dequant_dot_product_core gdq_checker u_gdq_checker (.*);

`default_nettype wire

// ===== sim/tb_gf4_dequant_dot_product_core.sv =====
// Self-checking testbench for gf4_dequant_dot_product_core: drives row groups over the
// valid/stall input channel, predicts row sums and flags, and checks each result.
// Depends on gdq_pkg and the core RTL only.
module tb_gf4_dequant_dot_product_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gdq_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 780;
  localparam int SAT_GROUPS   = 1175;
  localparam int REPORT_LIMIT = 10;

  // fp8 e5m2 scales: sign, exponent 6:2, mantissa 1:0
  localparam logic [SCALE_W-1:0] SC_ZERO     = 8'h00;
  localparam logic [SCALE_W-1:0] SC_SUB1     = 8'h01;
  localparam logic [SCALE_W-1:0] SC_SUB3     = 8'h03;
  localparam logic [SCALE_W-1:0] SC_SUB2_NEG = 8'h82;
  localparam logic [SCALE_W-1:0] SC_MIN_NORM = 8'h04;
  localparam logic [SCALE_W-1:0] SC_ONE      = 8'h3C;
  localparam logic [SCALE_W-1:0] SC_MAX      = 8'h7B;
  localparam logic [SCALE_W-1:0] SC_MAX_NEG  = 8'hFB;
  localparam logic [SCALE_W-1:0] SC_INF      = 8'h7C;
  localparam logic [SCALE_W-1:0] SC_NAN      = 8'h7E;
  localparam logic [SCALE_W-1:0] SC_NAN_NEG  = 8'hFF;

  // code fields for all eight lanes, lane 0 in the low bits
  localparam logic [LANES*CODE_W-1:0] CODES_ASCEND = 24'hFAC688;
  localparam logic [LANES*CODE_W-1:0] CODES_ALL0   = 24'h000000;
  localparam logic [LANES*CODE_W-1:0] CODES_ALL7   = 24'hFFFFFF;
  localparam logic [LANES*CODE_W-1:0] CODES_NULL   = {LANES{3'd4}};

  localparam logic [ACT_W-1:0] ACT_MAX = 16'h7FFF;
  localparam logic [ACT_W-1:0] ACT_MIN = 16'h8000;

  typedef struct packed {
    logic [GROUP_W-1:0]            grp;
    logic [LANES-1:0][ACT_W-1:0]   act;
    logic [TAG_W-1:0]              tag;
    logic                          last;
  } group_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic [TAG_W-1:0]        tag;
    logic                    sat;
    logic                    bad;
  } row_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid        = 1'b0;
  logic                     in_stall;
  logic [GROUP_W-1:0]       in_weight_group = '0;
  logic signed [ACT_W-1:0]  in_act_0        = '0;
  logic signed [ACT_W-1:0]  in_act_1        = '0;
  logic signed [ACT_W-1:0]  in_act_2        = '0;
  logic signed [ACT_W-1:0]  in_act_3        = '0;
  logic signed [ACT_W-1:0]  in_act_4        = '0;
  logic signed [ACT_W-1:0]  in_act_5        = '0;
  logic signed [ACT_W-1:0]  in_act_6        = '0;
  logic signed [ACT_W-1:0]  in_act_7        = '0;
  logic [TAG_W-1:0]         in_row_tag      = '0;
  logic                     in_last_group   = 1'b0;
  logic                     out_valid;
  logic                     out_stall       = 1'b1;
  logic signed [ACC_W-1:0]  out_dot_sum;
  logic [TAG_W-1:0]         out_row_tag_out;
  logic                     out_saturated;
  logic                     out_bad_scale;

  // predicted row state
  logic signed [ACC_W-1:0] row_acc     = '0;
  logic                    row_clipped = 1'b0;
  logic                    row_bad     = 1'b0;
  row_result_t             pending_rows [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int tx_idle_pct    = IDLE_PCT;
  int rx_idle_pct    = IDLE_PCT;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  gf4_dequant_dot_product_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_weight_group (in_weight_group),
    .in_act_0        (in_act_0),
    .in_act_1        (in_act_1),
    .in_act_2        (in_act_2),
    .in_act_3        (in_act_3),
    .in_act_4        (in_act_4),
    .in_act_5        (in_act_5),
    .in_act_6        (in_act_6),
    .in_act_7        (in_act_7),
    .in_row_tag      (in_row_tag),
    .in_last_group   (in_last_group),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dot_sum     (out_dot_sum),
    .out_row_tag_out (out_row_tag_out),
    .out_saturated   (out_saturated),
    .out_bad_scale   (out_bad_scale)
  );

  always #CLK_HALF clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Add one accepted group into the predicted row; queue the row result on a last group
  task automatic accumulate_group(input group_item_t it);
    logic [SCALE_W-1:0]      sc;
    logic [EXP_W-1:0]        ex;
    longint                  mag;
    longint                  term;
    int                      shift;
    int                      k;
    logic [ACC_W:0]          wide;
    row_result_t             res;
    sc = it.grp[SCALE_W-1:0];
    ex = sc[6:2];
    if (ex == EXP_INF_NAN) begin
      row_bad = 1'b1;
    end else begin
      mag   = (ex == EXP_SUBNORM) ? longint'(sc[1:0]) : 4 + longint'(sc[1:0]);
      shift = (ex == EXP_SUBNORM) ? int'(SUBNORM_SHIFT) : int'(ex);
      for (k = 0; k < LANES; k++) begin
        term = longint'(4 - int'(it.grp[CODE_BASE + CODE_W*k +: CODE_W])) * mag
             * longint'($signed(it.act[k]));
        term = term <<< shift;
        if (sc[7]) term = -term;
        // add with one guard bit and clip on overflow
        wide = {row_acc[ACC_W-1], row_acc} + {term[63], term};
        if (wide[ACC_W] != wide[ACC_W-1]) begin
          row_acc     = wide[ACC_W] ? ACC_MIN : ACC_MAX;
          row_clipped = 1'b1;
        end else begin
          row_acc = wide[ACC_W-1:0];
        end
      end
    end
    if (it.last) begin
      res.sum = row_acc;
      res.tag = it.tag;
      res.sat = row_clipped;
      res.bad = row_bad;
      pending_rows.push_back(res);
      row_acc     = '0;
      row_clipped = 1'b0;
      row_bad     = 1'b0;
    end
  endtask

  // Check each accepted result against the oldest predicted row
  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: sum %0d tag %h sat %b bad %b",
                   out_dot_sum, out_row_tag_out, out_saturated, out_bad_scale);
      end else begin
        want = pending_rows.pop_front();
        if (out_dot_sum !== want.sum || out_row_tag_out !== want.tag ||
            out_saturated !== want.sat || out_bad_scale !== want.bad) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("row %h mismatch: expected sum %0d sat %b bad %b, got sum %0d tag %h sat %b bad %b",
                     want.tag, want.sum, want.sat, want.bad,
                     out_dot_sum, out_row_tag_out, out_saturated, out_bad_scale);
        end
      end
    end
  end

  function automatic group_item_t make_item(input logic [SCALE_W-1:0] scale,
                                            input logic [LANES*CODE_W-1:0] codes,
                                            input logic [ACT_W-1:0] a,
                                            input logic [TAG_W-1:0] tag,
                                            input logic last);
    group_item_t it;
    it.grp  = {codes, scale};
    it.act  = {LANES{a}};
    it.tag  = tag;
    it.last = last;
    return it;
  endfunction

  // Offer one group after random idle cycles; return at the edge that accepts it
  task automatic send_group(input group_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_weight_group <= it.grp;
    in_act_0        <= it.act[0];
    in_act_1        <= it.act[1];
    in_act_2        <= it.act[2];
    in_act_3        <= it.act[3];
    in_act_4        <= it.act[4];
    in_act_5        <= it.act[5];
    in_act_6        <= it.act[6];
    in_act_7        <= it.act[7];
    in_row_tag      <= it.tag;
    in_last_group   <= it.last;
    do @(posedge clk); while (in_stall);
    accumulate_group(it);
  endtask

  // Hold the input idle until every predicted row has come out
  task automatic wait_rows_drained();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  // Field extremes, each scale class and the flag cases
  task automatic test_directed_cases();
    group_item_t it;
    send_group(make_item(SC_ZERO, CODES_ASCEND, ACT_MAX, 16'h0000, 1'b1));
    send_group(make_item(SC_MAX, CODES_NULL, ACT_MIN, 16'hFFFF, 1'b1));
    send_group(make_item(SC_SUB1, CODES_ASCEND, ACT_MIN, 16'h0002, 1'b0));
    send_group(make_item(SC_SUB3, CODES_ALL7, ACT_MAX, 16'h0002, 1'b0));
    send_group(make_item(SC_SUB2_NEG, CODES_ASCEND, 16'h0001, 16'h0002, 1'b1));
    send_group(make_item(SC_MIN_NORM, CODES_ALL0, 16'h0001, 16'h0003, 1'b1));
    send_group(make_item(SC_MAX, CODES_ALL0, ACT_MAX, 16'h0004, 1'b0));
    send_group(make_item(SC_MAX_NEG, CODES_ALL7, ACT_MIN, 16'h0004, 1'b1));
    // infinite scale flags the row and skips its own terms only
    send_group(make_item(SC_INF, CODES_ALL0, ACT_MAX, 16'h0005, 1'b0));
    send_group(make_item(SC_ONE, CODES_ASCEND, 16'h1000, 16'h0005, 1'b1));
    send_group(make_item(SC_NAN_NEG, CODES_ASCEND, ACT_MIN, 16'h0006, 1'b1));
    send_group(make_item(SC_ONE, CODES_ALL7, ACT_MAX, 16'h0007, 1'b0));
    send_group(make_item(SC_NAN, CODES_ALL0, ACT_MAX, 16'h0007, 1'b1));
    // flags must be clear again on the next row
    send_group(make_item(SC_ONE, CODES_ALL0, 16'h0001, 16'h0008, 1'b1));
    it = make_item(SC_MAX, CODES_ASCEND, ACT_MAX, 16'hFFFF, 1'b1);
    it.act = {4{ACT_MIN, ACT_MAX}};
    send_group(it);
    it = make_item(SC_MAX_NEG, CODES_ASCEND, ACT_MIN, 16'h8000, 1'b1);
    it.act = {4{ACT_MAX, ACT_MIN}};
    send_group(it);
  endtask

  // Drive the sum into the upper limit, then back off after the clip
  task automatic test_saturation();
    int g;
    for (g = 0; g < SAT_GROUPS; g++)
      send_group(make_item(SC_MAX, CODES_ALL0, ACT_MAX, 16'h0100, 1'b0));
    for (g = 0; g < 4; g++)
      send_group(make_item(SC_MAX_NEG, CODES_ALL0, ACT_MAX, 16'h0100, 1'b0));
    send_group(make_item(SC_ONE, CODES_ASCEND, 16'h1000, 16'h0100, 1'b1));
  endtask

  // Long result hold-off so the core fills and stalls its input, then a full drain
  task automatic test_backpressure();
    int r;
    tx_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    for (r = 0; r < 12; r++)
      send_group(make_item(SC_ONE, CODES_ASCEND, 16'($urandom), 16'(r), 1'b1));
    wait_rows_drained();
    for (r = 0; r < 6; r++)
      send_group(make_item(SC_SUB3, CODES_ALL7, 16'($urandom), 16'h0200, r == 5));
    wait_rows_drained();
    tx_idle_pct = IDLE_PCT;
  endtask

  // Random rows, mostly short with the odd long one, and a stretch without idling
  task automatic test_random_rows();
    group_item_t it;
    int          sent;
    int          len;
    int          g;
    int          k;
    logic [TAG_W-1:0] tag;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 200 && sent < 500) begin
        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
      end else begin
        tx_idle_pct  = IDLE_PCT;
        rx_idle_pct <= IDLE_PCT;
      end
      len = ($urandom_range(99) < 5) ? $urandom_range(40, 20) : $urandom_range(6, 1);
      tag = 16'($urandom);
      for (g = 0; g < len; g++) begin
        it.grp = $urandom;
        case ($urandom_range(9))
          0: it.grp[SCALE_W-1:0] = SC_INF;
          1: it.grp[SCALE_W-1:0] = SC_MAX;
          2: it.grp[SCALE_W-1:0] = SC_MAX_NEG;
          3: it.grp[SCALE_W-1:0] = {1'($urandom_range(1)), 5'd0, 2'($urandom)};
          default: ;
        endcase
        for (k = 0; k < LANES; k++) begin
          if ($urandom_range(9) == 0)
            it.act[k] = $urandom_range(1) ? ACT_MAX : ACT_MIN;
          else
            it.act[k] = 16'($urandom);
        end
        it.tag  = tag;
        it.last = (g == len - 1);
        send_group(it);
        sent++;
      end
    end
    rx_idle_pct <= IDLE_PCT;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_saturation();
    test_backpressure();
    test_random_rows();
    wait_rows_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_rows.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/gdq_pkg.sv
design/gdq_lane.sv
design/gdq_merge.sv
design/gf4_dequant_dot_product_core.sv
design/gdq_checker.sv
sim/tb_gf4_dequant_dot_product_core.sv
